// ===== src/sibc_pkg.sv =====
// Shared types, constants and helpers for the sample-in-ball challenge sampler.
`default_nettype none
package sibc_pkg;

  // Polynomial geometry.
  localparam int COEFFS     = 256;
  localparam int GROUPS     = COEFFS / 4;
  localparam int GROUP_W    = $clog2(GROUPS);
  localparam int SIGN_BYTES = 8;
  localparam int CMDQ_DEPTH = 4;

  // Weight register limits and reset value.
  localparam logic [6:0] WEIGHT_RESET = 7'd60;
  localparam logic [6:0] WEIGHT_MIN   = 7'd1;
  localparam logic [6:0] WEIGHT_MAX   = 7'd64;

  // Ternary coefficient codes in two's complement.
  typedef logic [1:0] coef_t;
  localparam coef_t COEF_ZERO = 2'b00;
  localparam coef_t COEF_POS  = 2'b01;
  localparam coef_t COEF_NEG  = 2'b11;

  // One placement handed from the front end to the store.
  typedef struct packed {
    logic [7:0] idx;
    logic [7:0] pos;
    logic       sign;
    logic       last;
  } place_cmd_t;

  // Command queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } cmdq_stat_t;

  // One result group of four coefficients.
  typedef struct packed {
    logic                  last;
    coef_t                 c3;
    coef_t                 c2;
    coef_t                 c1;
    coef_t                 c0;
    logic [GROUP_W-1:0]    grp;
  } group_t;

  // First placement position for a given weight; out-of-range weights are clamped.
  function automatic logic [7:0] start_pos(input logic [6:0] w);
    logic [6:0] e;
    begin
      e = w;
      if (w < WEIGHT_MIN) begin
        e = WEIGHT_MIN;
      end else if (w > WEIGHT_MAX) begin
        e = WEIGHT_MAX;
      end
      return 8'(9'(COEFFS) - {2'b00, e});
    end
  endfunction

  // Coefficient code for a sign bit.
  function automatic coef_t sign_code(input logic s);
    return s ? COEF_NEG : COEF_POS;
  endfunction

endpackage
`default_nettype wire

// ===== src/sample_in_ball_challenge_core.sv =====
// Sign bytes and rejected indexes are taken one per cycle while the command queue has room;
// a placement holds the store's single write port (moved value, then new sign), overlapped
// with the next read. After the final placement the 64 groups leave in order; a four-entry
// command queue lets the input run on while the store is busy.
// Reset is synchronous and active low: weight 60, store valid bits cleared.
// A weight write restarts the sampler and empties the queue and the store the same way.
`default_nettype none
module sample_in_ball_challenge_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration: weight (tau) in bits 6:0.
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_wdata,
  // Input stream; tdata: stream_byte [7:0].
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,
  // Result stream; tdata: group_index [5:0], coef_zero [7:6], coef_one [9:8],
  // coef_two [11:10], coef_three [13:12], zero pad [15:14]; tlast: last_group.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,
  output logic             out_tlast
);

  logic                 push;
  sibc_pkg::place_cmd_t push_cmd;
  logic                 pop;
  sibc_pkg::place_cmd_t q_head;
  sibc_pkg::cmdq_stat_t q_stat;
  sibc_pkg::group_t     grp;

  // Front end: sign word, rejection and position tracking.
  sibc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata),
    .q_stat    (q_stat),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // Placement queue.
  sibc_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .flush    (cfg_we),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  // Store, placement sequencer and readout.
  sibc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .flush     (cfg_we),
    .q_stat    (q_stat),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_group (grp)
  );

  // Pack the result group onto the output transfer.
  assign out_tdata = {2'b00, grp.c3, grp.c2, grp.c1, grp.c0, grp.grp};
  assign out_tlast = grp.last;

endmodule
`default_nettype wire

// ===== src/sibc_front.sv =====
// Front end: gathers the sign word, filters candidate indexes and issues placements.
`default_nettype none
module sibc_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [6:0]           cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           in_byte,
  input  wire sibc_pkg::cmdq_stat_t q_stat,
  output logic                      push,
  output sibc_pkg::place_cmd_t      push_cmd
);

  logic [6:0]  weight_r;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [63:0] sign_r, sign_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic        accept;
  logic        sign_phase;
  logic        last_place;

  // A byte is taken whenever the command queue has room.
  assign in_ready   = !q_stat.full;
  assign accept     = in_valid && in_ready;
  assign sign_phase = (cnt_r != 4'(sibc_pkg::SIGN_BYTES));
  assign push       = accept && !sign_phase && (in_byte <= pos_r);
  assign last_place = (pos_r == 8'hFF);

  assign push_cmd.idx  = in_byte;
  assign push_cmd.pos  = pos_r;
  assign push_cmd.sign = sign_r[0];
  assign push_cmd.last = last_place;

  // Next sampler state for one accepted byte.
  always_comb begin
    cnt_nxt  = cnt_r;
    sign_nxt = sign_r;
    pos_nxt  = pos_r;
    if (accept && sign_phase) begin
      // Shift in from the top so the first byte ends up in the low bits.
      sign_nxt = {in_byte, sign_r[63:8]};
      cnt_nxt  = 4'(cnt_r + 4'd1);
    end else if (push) begin
      if (last_place) begin
        cnt_nxt  = '0;
        sign_nxt = '0;
        pos_nxt  = sibc_pkg::start_pos(weight_r);
      end else begin
        sign_nxt = {1'b0, sign_r[63:1]};
        pos_nxt  = 8'(pos_r + 8'd1);
      end
    end
  end

  // A weight write restarts the sampler at once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= sibc_pkg::WEIGHT_RESET;
      cnt_r    <= '0;
      sign_r   <= '0;
      pos_r    <= sibc_pkg::start_pos(sibc_pkg::WEIGHT_RESET);
    end else if (cfg_we) begin
      weight_r <= cfg_wdata;
      cnt_r    <= '0;
      sign_r   <= '0;
      pos_r    <= sibc_pkg::start_pos(cfg_wdata);
    end else begin
      cnt_r    <= cnt_nxt;
      sign_r   <= sign_nxt;
      pos_r    <= pos_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/sibc_cmdq.sv =====
// Short command queue between the front end and the coefficient store.
`default_nettype none
module sibc_cmdq (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 flush,
  input  wire logic                 push,
  input  wire sibc_pkg::place_cmd_t push_cmd,
  input  wire logic                 pop,
  output sibc_pkg::place_cmd_t      head,
  output sibc_pkg::cmdq_stat_t      stat
);

  localparam int PtrW = $clog2(sibc_pkg::CMDQ_DEPTH);

  sibc_pkg::place_cmd_t entry_r [sibc_pkg::CMDQ_DEPTH];
  logic [PtrW-1:0] rd_ptr_r;
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW:0]   cnt_r;
  logic            do_push;
  logic            do_pop;

  assign stat.full  = (cnt_r == (PtrW+1)'(sibc_pkg::CMDQ_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = entry_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= PtrW'(wr_ptr_r + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_r <= PtrW'(rd_ptr_r + 1'b1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= (PtrW+1)'(cnt_r + 1'b1);
        2'b01:   cnt_r <= (PtrW+1)'(cnt_r - 1'b1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/sibc_back.sv =====
// Back end: coefficient store, placement sequencer and group readout.
`default_nettype none
module sibc_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 flush,
  input  wire sibc_pkg::cmdq_stat_t q_stat,
  input  wire sibc_pkg::place_cmd_t q_head,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output sibc_pkg::group_t          out_group
);

  localparam int GrpW = sibc_pkg::GROUP_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WPOS,
    ST_WIDX,
    ST_EMIT
  } state_t;

  state_t                   state_r;
  sibc_pkg::place_cmd_t     cur_r;
  logic                     fwd_r;
  sibc_pkg::coef_t          fwdv_r;

  // Store: one row per group, written one coefficient at a time.
  sibc_pkg::coef_t [3:0]    mem_r [sibc_pkg::GROUPS];
  logic [sibc_pkg::GROUPS-1:0][3:0] vld_r;
  sibc_pkg::coef_t [3:0]    memq_r;
  logic [3:0]               vldq_r;

  // Readout.
  logic [GrpW:0]            grp_r;
  logic                     rinf_r;
  logic [GrpW-1:0]          rgrp_r;
  sibc_pkg::group_t         ofq_r [2];
  logic                     ohead_r;
  logic [1:0]               ocnt_r;

  logic                     emit_issue;
  logic                     emit_done;
  logic                     rd_en;
  logic [GrpW-1:0]          rd_row;
  logic                     wr_en;
  logic [7:0]               wr_addr;
  sibc_pkg::coef_t          wr_data;
  sibc_pkg::coef_t          rd_val;
  sibc_pkg::group_t         push_grp;
  logic                     opush;
  logic                     opop;
  logic                     owptr;
  logic [2:0]               credit;

  // Old value of the indexed coefficient, with bypass of a write still landing.
  always_comb begin
    if (fwd_r) begin
      rd_val = fwdv_r;
    end else if (vldq_r[cur_r.idx[1:0]]) begin
      rd_val = memq_r[cur_r.idx[1:0]];
    end else begin
      rd_val = sibc_pkg::COEF_ZERO;
    end
  end

  // Dequeue a placement when idle or as the previous one finishes.
  assign pop = !q_stat.empty &&
               ((state_r == ST_IDLE) || ((state_r == ST_WIDX) && !cur_r.last));

  // Readout keeps at most two groups between the read port and the output.
  assign credit     = 3'(ocnt_r) + 3'(rinf_r);
  assign emit_issue = (state_r == ST_EMIT) && !grp_r[GrpW] && (credit < 3'd2);
  assign emit_done  = (state_r == ST_EMIT) && grp_r[GrpW] && !rinf_r;

  // Read port selection.
  always_comb begin
    rd_en  = pop || emit_issue;
    rd_row = emit_issue ? grp_r[GrpW-1:0] : q_head.idx[7:2];
  end

  // Write port selection: the moved value first, then the new sign.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_r.pos;
    wr_data = rd_val;
    case (state_r)
      ST_WPOS: begin
        wr_en   = 1'b1;
        wr_addr = cur_r.pos;
        wr_data = rd_val;
      end
      ST_WIDX: begin
        wr_en   = 1'b1;
        wr_addr = cur_r.idx;
        wr_data = sibc_pkg::sign_code(cur_r.sign);
      end
      default: begin
        wr_en   = 1'b0;
      end
    endcase
  end

  // Store array and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr[7:2]][wr_addr[1:0]] <= wr_data;
    end
    if (rd_en) begin
      memq_r <= mem_r[rd_row];
      vldq_r <= vld_r[rd_row];
    end
  end

  // Group captured from the read port, unwritten entries read as zero.
  always_comb begin
    push_grp.grp  = rgrp_r;
    push_grp.c0   = vldq_r[0] ? memq_r[0] : sibc_pkg::COEF_ZERO;
    push_grp.c1   = vldq_r[1] ? memq_r[1] : sibc_pkg::COEF_ZERO;
    push_grp.c2   = vldq_r[2] ? memq_r[2] : sibc_pkg::COEF_ZERO;
    push_grp.c3   = vldq_r[3] ? memq_r[3] : sibc_pkg::COEF_ZERO;
    push_grp.last = (rgrp_r == GrpW'(sibc_pkg::GROUPS - 1));
  end

  assign opush     = rinf_r;
  assign out_valid = (ocnt_r != 2'd0);
  assign opop      = out_valid && out_ready;
  assign owptr     = ohead_r ^ ocnt_r[0];
  assign out_group = ofq_r[ohead_r];

  // Payload registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r  <= q_head;
      fwdv_r <= sibc_pkg::sign_code(cur_r.sign);
    end
    if (emit_issue) begin
      rgrp_r <= grp_r[GrpW-1:0];
    end
    if (opush) begin
      ofq_r[owptr] <= push_grp;
    end
  end

  // Sequencer state, valid bits and output queue control.
  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      state_r <= ST_IDLE;
      fwd_r   <= 1'b0;
      vld_r   <= '0;
      grp_r   <= '0;
      rinf_r  <= 1'b0;
      ohead_r <= 1'b0;
      ocnt_r  <= '0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr[7:2]][wr_addr[1:0]] <= 1'b1;
      end
      rinf_r <= emit_issue;
      unique case (state_r)
        ST_IDLE: begin
          if (pop) begin
            fwd_r   <= 1'b0;
            state_r <= ST_WPOS;
          end
        end
        ST_WPOS: begin
          state_r <= ST_WIDX;
        end
        ST_WIDX: begin
          if (cur_r.last) begin
            grp_r   <= '0;
            state_r <= ST_EMIT;
          end else if (pop) begin
            fwd_r   <= (q_head.idx == cur_r.idx);
            state_r <= ST_WPOS;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (emit_issue) begin
            grp_r <= (GrpW+1)'(grp_r + 1'b1);
          end
          if (emit_done) begin
            vld_r   <= '0;
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
      if (opop) begin
        ohead_r <= ~ohead_r;
      end
      case ({opush, opop})
        2'b10:   ocnt_r <= 2'(ocnt_r + 2'd1);
        2'b01:   ocnt_r <= 2'(ocnt_r - 2'd1);
        default: ocnt_r <= ocnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire
